### rtl/bmea_pkg.sv
// ============================================================================
// bmea_pkg - shared types and constants of the 3x3 edge-aware box mean
// Pixel, coordinate and sum types, register codes, reciprocal constants and
// the structs that travel between the pipeline stages.
// ============================================================================
package bmea_pkg;

    localparam int PIX_W      = 8;
    localparam int COORD_W    = 4;
    localparam int SIDE_W     = 5;
    localparam int SUM_W      = 12;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [SIDE_W-1:0] SIDE_RESET = 5'd8;

    // Reciprocals scaled by 2^15. Over sums below 4096 the product shifted
    // right by 15 equals the truncated quotient.
    localparam int               RCP_SHIFT = 15;
    localparam int               RCP_W     = 14;
    localparam int               PROD_W    = SUM_W + RCP_W;
    localparam logic [RCP_W-1:0] RCP_4     = 14'd8192;
    localparam logic [RCP_W-1:0] RCP_6     = 14'd5462;
    localparam logic [RCP_W-1:0] RCP_9     = 14'd3641;

    typedef logic [PIX_W-1:0]   t_pix;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [SUM_W-1:0]   t_sum;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IMAGE_SIDE = 1'b0
    } t_reg_idx;

    typedef enum logic [1:0] {
        DIV_4 = 2'd0,
        DIV_6 = 2'd1,
        DIV_9 = 2'd2
    } t_div;

    // Position of a pixel and which of its results exist.
    typedef struct packed {
        t_coord row;
        t_coord col;
        logic   has_up;
        logic   has_up2;
        logic   has_left;
        logic   has_left2;
        logic   row_last;
        logic   col_last;
    } t_meta;

    // One column of the window: the current row and the two above it.
    typedef struct packed {
        t_pix cur;
        t_pix above1;
        t_pix above2;
    } t_column;

    typedef struct packed {
        t_sum   sum;
        t_div   div;
        t_coord row;
        t_coord col;
        logic   run_last;
        logic   frame_done;
    } t_sum_beat;

endpackage

### rtl/bmea_if.sv
// ============================================================================
// bmea_if - stream channels of the 3x3 edge-aware box mean
// A pixel channel and a result channel, each with valid/ready.
// ============================================================================
interface bmea_pix_if;
    logic            valid;
    logic            ready;
    bmea_pkg::t_pix  pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface bmea_res_if;
    logic              valid;
    logic              ready;
    bmea_pkg::t_coord  out_row;
    bmea_pkg::t_coord  out_column;
    bmea_pkg::t_pix    smoothed;
    logic              run_last;
    logic              frame_done;

    modport source (output valid, output out_row, output out_column, output smoothed,
                     output run_last, output frame_done, input ready);
    modport sink   (input valid, input out_row, input out_column, input smoothed,
                     input run_last, input frame_done, output ready);
endinterface

### rtl/bmea_cfg_regs.sv
// ============================================================================
// bmea_cfg_regs - APB configuration register
// Holds the image side and the last valid index derived from it.
// ============================================================================
module bmea_cfg_regs #(
    parameter int MAX_SIDE = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [bmea_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [bmea_pkg::APB_DATA_W-1:0]       pwdata,
    output logic [bmea_pkg::APB_DATA_W-1:0]       prdata,
    output logic                                  pready,
    output logic [$clog2(MAX_SIDE)-1:0]           o_last,
    output logic                                  o_restart
);

    localparam int CW = $clog2(MAX_SIDE);

    logic [bmea_pkg::SIDE_W-1:0] r_side;
    logic [CW-1:0]               r_last;
    bmea_pkg::t_reg_idx          reg_idx;
    logic                        wr_en;
    logic                        wr_side;

    // Out-of-range sides act as the nearest legal side.
    function automatic logic [CW-1:0] last_index(logic [bmea_pkg::SIDE_W-1:0] side);
        if (side < bmea_pkg::SIDE_W'(2)) begin
            return CW'(1);
        end else if (int'(side) > MAX_SIDE) begin
            return CW'(MAX_SIDE - 1);
        end else begin
            return CW'(side - 1'b1);
        end
    endfunction

    assign reg_idx = bmea_pkg::t_reg_idx'(paddr[bmea_pkg::APB_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    always_comb begin
        wr_side = 1'b0;
        prdata  = '0;
        unique case (reg_idx)
            bmea_pkg::REG_IMAGE_SIDE: begin
                wr_side = wr_en;
                prdata  = bmea_pkg::APB_DATA_W'(r_side);
            end
            default: begin
                wr_side = 1'b0;
                prdata  = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_side <= bmea_pkg::SIDE_RESET;
            r_last <= last_index(bmea_pkg::SIDE_RESET);
        end else if (wr_side) begin
            r_side <= pwdata[bmea_pkg::SIDE_W-1:0];
            r_last <= last_index(pwdata[bmea_pkg::SIDE_W-1:0]);
        end
    end

    assign o_last    = r_last;
    assign o_restart = wr_side;

endmodule

### rtl/bmea_line_store.sv
// ============================================================================
// bmea_line_store - raster counters and three-row line store
// Writes each accepted pixel and reads the two rows above it in the same
// column, handing one window column per pixel to the window stage.
// ============================================================================
module bmea_line_store #(
    parameter int MAX_SIDE = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [$clog2(MAX_SIDE)-1:0]   i_last,
    input  logic                          i_restart,
    bmea_pix_if.sink                      i_pix,
    input  logic                          i_s2_ready,
    output logic                          o_s1_valid,
    output bmea_pkg::t_meta               o_s1_meta,
    output bmea_pkg::t_column             o_s1_col
);

    localparam int CW    = $clog2(MAX_SIDE);
    localparam int DEPTH = 3 * MAX_SIDE;
    localparam int AW    = $clog2(DEPTH);

    bmea_pkg::t_pix  r_mem [DEPTH];

    logic [CW-1:0]   r_row, n_row;
    logic [CW-1:0]   r_col, n_col;
    logic [1:0]      r_rsel, n_rsel;
    logic            r_s1_vld;
    bmea_pkg::t_meta r_s1_meta, n_meta;
    bmea_pkg::t_pix  r_s1_pix;
    bmea_pkg::t_pix  r_rd_above1;
    bmea_pkg::t_pix  r_rd_above2;

    logic            s1_free;
    logic            accept;
    logic [1:0]      sel_above1;
    logic [1:0]      sel_above2;
    logic [AW-1:0]   wr_addr;
    logic [AW-1:0]   rd_addr_above1;
    logic [AW-1:0]   rd_addr_above2;

    assign s1_free     = !r_s1_vld || i_s2_ready;
    assign i_pix.ready = s1_free;
    assign accept      = i_pix.valid && s1_free;

    // Rows live in the store at row number modulo three.
    always_comb begin
        case (r_rsel)
            2'd0: begin
                sel_above1 = 2'd2;
                sel_above2 = 2'd1;
            end
            2'd1: begin
                sel_above1 = 2'd0;
                sel_above2 = 2'd2;
            end
            default: begin
                sel_above1 = 2'd1;
                sel_above2 = 2'd0;
            end
        endcase
    end

    assign wr_addr        = AW'(int'(r_rsel) * MAX_SIDE + int'(r_col));
    assign rd_addr_above1 = AW'(int'(sel_above1) * MAX_SIDE + int'(r_col));
    assign rd_addr_above2 = AW'(int'(sel_above2) * MAX_SIDE + int'(r_col));

    // The write always targets the current row and the reads the two others,
    // so a read never meets the write of the same cycle.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_mem[wr_addr] <= i_pix.pixel;
            r_rd_above1    <= r_mem[rd_addr_above1];
            r_rd_above2    <= r_mem[rd_addr_above2];
        end
    end

    always_comb begin
        n_row  = r_row;
        n_col  = r_col;
        n_rsel = r_rsel;
        if (i_restart) begin
            n_row  = '0;
            n_col  = '0;
            n_rsel = 2'd0;
        end else if (accept) begin
            if (r_col == i_last) begin
                n_col = '0;
                if (r_row == i_last) begin
                    n_row  = '0;
                    n_rsel = 2'd0;
                end else begin
                    n_row  = r_row + 1'b1;
                    n_rsel = (r_rsel == 2'd2) ? 2'd0 : r_rsel + 2'd1;
                end
            end else begin
                n_col = r_col + 1'b1;
            end
        end
    end

    always_comb begin
        n_meta.row       = bmea_pkg::t_coord'(r_row);
        n_meta.col       = bmea_pkg::t_coord'(r_col);
        n_meta.has_up    = (r_row != '0);
        n_meta.has_up2   = (r_row > CW'(1));
        n_meta.has_left  = (r_col != '0);
        n_meta.has_left2 = (r_col > CW'(1));
        n_meta.row_last  = (r_row == i_last);
        n_meta.col_last  = (r_col == i_last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_col    <= '0;
            r_rsel   <= 2'd0;
            r_s1_vld <= 1'b0;
        end else begin
            r_row  <= n_row;
            r_col  <= n_col;
            r_rsel <= n_rsel;
            if (accept) begin
                r_s1_vld <= 1'b1;
            end else if (i_s2_ready) begin
                r_s1_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= n_meta;
            r_s1_pix  <= i_pix.pixel;
        end
    end

    assign o_s1_valid      = r_s1_vld;
    assign o_s1_meta       = r_s1_meta;
    assign o_s1_col.cur    = r_s1_pix;
    assign o_s1_col.above1 = r_rd_above1;
    assign o_s1_col.above2 = r_rd_above2;

`ifndef SYNTH
    a_pos_in_image: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_col <= i_last) && (r_row <= i_last))
        else $error("raster position lies outside the image");

    a_rsel_tracks_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_row == '0) |-> (r_rsel == 2'd0))
        else $error("store row select out of step with the row counter");
`endif

endmodule

### rtl/bmea_window.sv
// ============================================================================
// bmea_window - 3x3 window and neighborhood sum
// Shifts one column per pixel into the window and walks the results that the
// pixel releases, one masked nine-tap sum per cycle unless the divider stalls.
// ============================================================================
module bmea_window (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s1_valid,
    input  bmea_pkg::t_meta       i_s1_meta,
    input  bmea_pkg::t_column     i_s1_col,
    output logic                  o_s2_ready,
    input  logic                  i_s3_ready,
    output logic                  o_s3_valid,
    output bmea_pkg::t_sum_beat   o_s3
);

    // Column 0 is two pixels left of the newest, column 2 the newest.
    bmea_pkg::t_column   r_win [3];
    logic                r_s2_vld;
    bmea_pkg::t_meta     r_s2_meta;
    logic                r_ka;
    logic                r_kb;
    logic                r_s3_vld;
    bmea_pkg::t_sum_beat r_s3, n_s3;

    logic has_res;
    logic a_last;
    logic b_last;
    logic s3_free;
    logic emit;
    logic s2_done;
    logic s2_load;
    logic row0_in;
    logic col0_in;

    // A pixel releases results only when it has a row above and a column left.
    // r_ka picks the result row (above, then the last row itself) and r_kb
    // the result column in the same way.
    assign has_res    = r_s2_meta.has_up && r_s2_meta.has_left;
    assign a_last     = !r_s2_meta.row_last || r_ka;
    assign b_last     = !r_s2_meta.col_last || r_kb;
    assign s3_free    = !r_s3_vld || i_s3_ready;
    assign emit       = r_s2_vld && has_res && s3_free;
    assign s2_done    = r_s2_vld && (!has_res || (s3_free && a_last && b_last));
    assign o_s2_ready = !r_s2_vld || s2_done;
    assign s2_load    = i_s1_valid && o_s2_ready;

    // Rows 1 and 2 and columns 1 and 2 are always inside the neighborhood;
    // the top row and the left column join only for the upper or left result
    // and only when they lie inside the image.
    assign row0_in = !r_ka && r_s2_meta.has_up2;
    assign col0_in = !r_kb && r_s2_meta.has_left2;

    always_comb begin
        n_s3.sum = bmea_pkg::t_sum'(r_win[1].above1) + bmea_pkg::t_sum'(r_win[1].cur)
                 + bmea_pkg::t_sum'(r_win[2].above1) + bmea_pkg::t_sum'(r_win[2].cur)
                 + (row0_in ? bmea_pkg::t_sum'(r_win[1].above2) : '0)
                 + (row0_in ? bmea_pkg::t_sum'(r_win[2].above2) : '0)
                 + (col0_in ? bmea_pkg::t_sum'(r_win[0].above1) : '0)
                 + (col0_in ? bmea_pkg::t_sum'(r_win[0].cur) : '0)
                 + ((row0_in && col0_in) ? bmea_pkg::t_sum'(r_win[0].above2) : '0);
        case ({row0_in, col0_in})
            2'b11:   n_s3.div = bmea_pkg::DIV_9;
            2'b00:   n_s3.div = bmea_pkg::DIV_4;
            default: n_s3.div = bmea_pkg::DIV_6;
        endcase
        n_s3.row        = r_ka ? r_s2_meta.row : r_s2_meta.row - 1'b1;
        n_s3.col        = r_kb ? r_s2_meta.col : r_s2_meta.col - 1'b1;
        n_s3.run_last   = a_last && b_last;
        n_s3.frame_done = a_last && b_last && r_s2_meta.row_last && r_s2_meta.col_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
            r_ka     <= 1'b0;
            r_kb     <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            if (s2_load) begin
                r_s2_vld <= 1'b1;
            end else if (s2_done) begin
                r_s2_vld <= 1'b0;
            end
            if (s2_done) begin
                r_ka <= 1'b0;
                r_kb <= 1'b0;
            end else if (emit) begin
                if (b_last) begin
                    r_kb <= 1'b0;
                    r_ka <= 1'b1;
                end else begin
                    r_kb <= 1'b1;
                end
            end
            if (emit) begin
                r_s3_vld <= 1'b1;
            end else if (i_s3_ready) begin
                r_s3_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_load) begin
            r_s2_meta <= i_s1_meta;
            r_win[0]  <= r_win[1];
            r_win[1]  <= r_win[2];
            r_win[2]  <= i_s1_col;
        end
        if (emit) begin
            r_s3 <= n_s3;
        end
    end

    assign o_s3_valid = r_s3_vld;
    assign o_s3       = r_s3;

`ifndef SYNTH
    a_second_row_only_at_bottom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_vld && r_ka) |-> r_s2_meta.row_last)
        else $error("second result row taken outside the last image row");

    a_last_result_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_done && has_res) |-> (emit && n_s3.run_last))
        else $error("pixel retired without marking its last result");

    a_sum_held_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s3_vld && !i_s3_ready) |=> (r_s3_vld && $stable(r_s3)))
        else $error("sum stage changed while stalled");
`endif

endmodule

### rtl/bmea_mean.sv
// ============================================================================
// bmea_mean - divide by the neighborhood size and drive the result channel
// Multiplies the sum by a scaled reciprocal of 4, 6 or 9 and holds the
// result beat in the output register.
// ============================================================================
module bmea_mean (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s3_valid,
    input  bmea_pkg::t_sum_beat   i_s3,
    output logic                  o_s3_ready,
    bmea_res_if.source            o_res
);

    logic                           r_vld;
    bmea_pkg::t_coord               r_row;
    bmea_pkg::t_coord               r_col;
    bmea_pkg::t_pix                 r_mean, n_mean;
    logic                           r_run_last;
    logic                           r_frame_done;

    logic                           out_free;
    logic                           load;
    logic [bmea_pkg::RCP_W-1:0]     rcp;
    logic [bmea_pkg::PROD_W-1:0]    prod;

    assign out_free   = !r_vld || o_res.ready;
    assign o_s3_ready = out_free;
    assign load       = i_s3_valid && out_free;

    always_comb begin
        unique case (i_s3.div)
            bmea_pkg::DIV_4: rcp = bmea_pkg::RCP_4;
            bmea_pkg::DIV_6: rcp = bmea_pkg::RCP_6;
            bmea_pkg::DIV_9: rcp = bmea_pkg::RCP_9;
            default:         rcp = bmea_pkg::RCP_9;
        endcase
        prod   = bmea_pkg::PROD_W'(i_s3.sum) * bmea_pkg::PROD_W'(rcp);
        n_mean = bmea_pkg::t_pix'(prod >> bmea_pkg::RCP_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (load) begin
            r_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_row        <= i_s3.row;
            r_col        <= i_s3.col;
            r_mean       <= n_mean;
            r_run_last   <= i_s3.run_last;
            r_frame_done <= i_s3.frame_done;
        end
    end

    assign o_res.valid      = r_vld;
    assign o_res.out_row    = r_row;
    assign o_res.out_column = r_col;
    assign o_res.smoothed   = r_mean;
    assign o_res.run_last   = r_run_last;
    assign o_res.frame_done = r_frame_done;

endmodule

### rtl/box_mean_3x3_edge_aware_top.sv
// ============================================================================
// box_mean_3x3_edge_aware_top - streaming 3x3 box mean with edge handling
// Top level: configuration register, line store, window and divider.
// ============================================================================
// The block smooths a square 8-bit image whose side (2 up to MAX_SIDE, set
// through the image_side register at byte address 0) arrives one pixel per
// beat in raster order. Every output pixel is the truncated mean of the
// pixels of its 3x3 neighborhood that lie inside the image, so corners
// average 4 pixels, edges 6 and the interior 9. A result is sent with its row
// and column as soon as the pixel below and right of it, clamped to the
// image, has arrived: pixels of the first row and of the first column send
// nothing, an ordinary pixel sends one result, a pixel of the last row or
// last column sends two, and the last pixel of the image sends four. run_last
// marks the last result of an input beat and frame_done the final result of
// the image. The input takes one pixel per clock cycle while the output is
// not stalled; a pixel that sends more than one result holds the input
// while the window stage computes one neighborhood sum per cycle for it.
// A result passes the line store, window, sum and output registers after its
// pixel is accepted, and the output register lets the next pixel enter while a
// result still waits. The line store keeps three rows of MAX_SIDE pixels in
// one memory with one write port and two registered read ports: each
// accepted pixel is written to its row and the two rows above are read in
// the same column, so the window needs no extra row buffers and no clearing
// pass follows reset. Writing image_side restarts the image at the next
// pixel; it is to be written only while no results are outstanding. Side
// values below 2 act as 2 and values above MAX_SIDE act as MAX_SIDE.
module box_mean_3x3_edge_aware_top #(
    parameter int MAX_SIDE = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bmea_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bmea_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bmea_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    bmea_pix_if.sink                          i_pix,
    bmea_res_if.source                        o_res
);

    localparam int CW = $clog2(MAX_SIDE);

    // Last valid row and column index, and the strobe that restarts the image.
    logic [CW-1:0]        last_idx;
    logic                 restart;

    // Line store to window: one column per accepted pixel.
    logic                 s1_valid;
    logic                 s2_ready;
    bmea_pkg::t_meta      s1_meta;
    bmea_pkg::t_column    s1_col;

    // Window to divider: one neighborhood sum per result beat.
    logic                 s3_valid;
    logic                 s3_ready;
    bmea_pkg::t_sum_beat  s3_beat;

    bmea_cfg_regs #(
        .MAX_SIDE (MAX_SIDE)
    ) u_cfg_regs (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .o_last    (last_idx),
        .o_restart (restart)
    );

    bmea_line_store #(
        .MAX_SIDE (MAX_SIDE)
    ) u_line_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_last     (last_idx),
        .i_restart  (restart),
        .i_pix      (i_pix),
        .i_s2_ready (s2_ready),
        .o_s1_valid (s1_valid),
        .o_s1_meta  (s1_meta),
        .o_s1_col   (s1_col)
    );

    // The window walks the results of one pixel while the line store
    // already holds the next one.
    bmea_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (s1_valid),
        .i_s1_meta  (s1_meta),
        .i_s1_col   (s1_col),
        .o_s2_ready (s2_ready),
        .i_s3_ready (s3_ready),
        .o_s3_valid (s3_valid),
        .o_s3       (s3_beat)
    );

    // The divider's output register parts the result channel from the
    // pipeline, so a stalled result does not block the input directly.
    bmea_mean u_mean (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s3_valid (s3_valid),
        .i_s3       (s3_beat),
        .o_s3_ready (s3_ready),
        .o_res      (o_res)
    );

endmodule

### tb/box_mean_3x3_edge_aware_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// box_mean_3x3_edge_aware_top_tb - self-checking bench of the 3x3 box mean
// Streams square images through the pixel channel, predicts every smoothed
// pixel with a software copy of the filter, and compares each result beat
// field by field. The image side is set over APB between images.
// ============================================================================
module box_mean_3x3_edge_aware_top_tb;

    localparam int SIDE_MAX       = 16;
    localparam int REG_STRIDE     = 4;
    localparam int SPARE_REG_IDX  = 1;   // no register lives here
    localparam int SETTLE_CYCLES  = 10;  // margin beyond the result latency
    localparam int LONG_HOLD      = 200;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam bmea_pkg::t_pix PIX_MIN = 8'h00;
    localparam bmea_pkg::t_pix PIX_MAX = 8'hFF;

    // One smoothed pixel as it leaves the block.
    typedef struct packed {
        bmea_pkg::t_coord out_row;
        bmea_pkg::t_coord out_column;
        bmea_pkg::t_pix   smoothed;
        logic             run_last;
        logic             frame_done;
    } t_mean_beat;

    // Keeps its own copy of the line store, the raster position and the side
    // register, and queues the smoothed pixels each accepted pixel releases.
    class window_mean_checker;
        bmea_pkg::t_pix              line_mem [3][SIDE_MAX];
        logic [bmea_pkg::SIDE_W-1:0] side_reg;
        int unsigned                 row_pos;
        int unsigned                 col_pos;
        t_mean_beat                  pending_means [$];
        int unsigned                 errors;

        function new();
            side_reg = bmea_pkg::SIDE_RESET;
            row_pos  = 0;
            col_pos  = 0;
            errors   = 0;
        endfunction

        function int unsigned eff_side();
            int unsigned s;
            s = 32'(side_reg);
            if (s < 2) s = 2;
            if (s > SIDE_MAX) s = SIDE_MAX;
            return s;
        endfunction

        function int unsigned pending();
            return pending_means.size();
        endfunction

        function void write_reg(int unsigned idx, logic [bmea_pkg::APB_DATA_W-1:0] value);
            if (idx == int'(bmea_pkg::REG_IMAGE_SIDE)) begin
                side_reg = value[bmea_pkg::SIDE_W-1:0];
                row_pos  = 0;
                col_pos  = 0;
            end
        endfunction

        // Truncated mean of the in-image part of the 3x3 window around (r, c).
        function bmea_pkg::t_pix window_mean(int unsigned r, int unsigned c,
                                             int unsigned side);
            int unsigned r_lo, r_hi, c_lo, c_hi, rr, cc, acc, n;
            r_lo = (r > 0) ? r - 1 : r;
            r_hi = (r + 1 < side) ? r + 1 : r;
            c_lo = (c > 0) ? c - 1 : c;
            c_hi = (c + 1 < side) ? c + 1 : c;
            acc  = 0;
            n    = 0;
            for (rr = r_lo; rr <= r_hi; rr++) begin
                for (cc = c_lo; cc <= c_hi; cc++) begin
                    acc += 32'(line_mem[rr % 3][cc]);
                    n++;
                end
            end
            return bmea_pkg::t_pix'(acc / n);
        endfunction

        function void note_pixel(bmea_pkg::t_pix value);
            int unsigned side, r, c, n_rows, n_cols, total, k, a, b;
            int unsigned rows_hit [2];
            int unsigned cols_hit [2];
            bit          frame_end;
            t_mean_beat  beat;
            side = eff_side();
            r    = (row_pos >= side) ? 0 : row_pos;
            c    = (col_pos >= side) ? 0 : col_pos;
            line_mem[r % 3][c] = value;

            n_rows = 0;
            n_cols = 0;
            if (r >= 1) begin
                rows_hit[n_rows] = r - 1;
                n_rows++;
            end
            if (r == side - 1) begin
                rows_hit[n_rows] = r;
                n_rows++;
            end
            if (c >= 1) begin
                cols_hit[n_cols] = c - 1;
                n_cols++;
            end
            if (c == side - 1) begin
                cols_hit[n_cols] = c;
                n_cols++;
            end
            total     = n_rows * n_cols;
            frame_end = (r == side - 1) && (c == side - 1);

            k = 0;
            for (a = 0; a < n_rows; a++) begin
                for (b = 0; b < n_cols; b++) begin
                    k++;
                    beat.out_row    = bmea_pkg::t_coord'(rows_hit[a]);
                    beat.out_column = bmea_pkg::t_coord'(cols_hit[b]);
                    beat.smoothed   = window_mean(rows_hit[a], cols_hit[b], side);
                    beat.run_last   = (k == total);
                    beat.frame_done = (k == total) && frame_end;
                    pending_means.push_back(beat);
                end
            end

            c++;
            if (c >= side) begin
                c = 0;
                r++;
                if (r >= side) r = 0;
            end
            row_pos = r;
            col_pos = c;
        endfunction

        function void field_check(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_mean_beat got);
            t_mean_beat want;
            if (pending_means.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got row %0d col %0d value %0d",
                         $time, got.out_row, got.out_column, got.smoothed);
                return;
            end
            want = pending_means.pop_front();
            field_check("out_row", 32'(want.out_row), 32'(got.out_row));
            field_check("out_column", 32'(want.out_column), 32'(got.out_column));
            field_check("smoothed", 32'(want.smoothed), 32'(got.smoothed));
            field_check("run_last", 32'(want.run_last), 32'(got.run_last));
            field_check("frame_done", 32'(want.frame_done), 32'(got.frame_done));
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            psel;
    logic                            penable;
    logic                            pwrite;
    logic [bmea_pkg::APB_ADDR_W-1:0] paddr;
    logic [bmea_pkg::APB_DATA_W-1:0] pwdata;
    logic [bmea_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    bmea_pix_if pix_ch ();
    bmea_res_if res_ch ();

    window_mean_checker board = new();

    // Idle rates of the two sides, in percent, changed between phases.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    // The receiver serves one long stall for every request raised here.
    int unsigned hold_asked;
    int unsigned hold_served;

    box_mean_3x3_edge_aware_top #(
        .MAX_SIDE (SIDE_MAX)
    ) i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_pix   (pix_ch),
        .o_res   (res_ch)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Driving tasks. Each one is entered and left at a falling edge.
    // ------------------------------------------------------------------------

    // Offers one pixel, with random idle cycles ahead of it, and holds it until
    // the block takes the beat. The checker learns of the pixel at that edge.
    task automatic send_pixel(input bmea_pkg::t_pix value);
        while ($urandom_range(99) < send_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= value;
        do @(posedge i_clk); while (!pix_ch.ready);
        board.note_pixel(value);
        @(negedge i_clk);
    endtask

    // Sends a run of pixels; a quarter of them sit at the extremes of the range.
    task automatic send_frame(input int unsigned count);
        int unsigned    k;
        bmea_pkg::t_pix value;
        for (k = 0; k < count; k++) begin
            case ($urandom_range(3))
                0:       value = ($urandom_range(1) != 0) ? PIX_MAX : PIX_MIN;
                default: value = bmea_pkg::t_pix'($urandom_range(255));
            endcase
            send_pixel(value);
        end
    endtask

    // Stops offering pixels and waits until every predicted result has come
    // back, then lets the pipeline settle so that a pixel with no result is
    // surely finished before the configuration changes.
    task automatic wait_results_done();
        pix_ch.valid <= 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // APB write: a setup cycle, then an access cycle that completes on pready.
    task automatic write_reg(input int unsigned idx,
                             input logic [bmea_pkg::APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= bmea_pkg::APB_ADDR_W'(idx * REG_STRIDE);
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        board.write_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Random images of random sides until the pixel budget is used up. Most
    // images are complete; some are cut short by a side write, which restarts
    // the raster, and after a complete image the side is sometimes kept so the
    // counters wrap straight into the next image. Sides above the maximum
    // clamp to the largest image, so those are always cut short.
    task automatic run_random_frames(input int unsigned pixel_budget);
        int unsigned                     sent, pick, side_val, eff, lim, count;
        logic [bmea_pkg::APB_DATA_W-1:0] reg_val;
        bit                              frame_whole;
        sent        = 0;
        frame_whole = 1'b0;
        while (sent < pixel_budget) begin
            if (!(frame_whole && $urandom_range(99) < 30)) begin
                pick = $urandom_range(99);
                if (pick < 10) side_val = $urandom_range(1, 0);
                else if (pick < 20) side_val = $urandom_range(31, 17);
                else side_val = $urandom_range(7, 2);
                reg_val = $urandom();
                reg_val[bmea_pkg::SIDE_W-1:0] = side_val[bmea_pkg::SIDE_W-1:0];
                wait_results_done();
                write_reg(int'(bmea_pkg::REG_IMAGE_SIDE), reg_val);
            end
            eff = board.eff_side();
            if (eff * eff > 64 || $urandom_range(99) < 25) begin
                lim         = (eff * eff - 1 < 40) ? eff * eff - 1 : 40;
                count       = $urandom_range(lim, 1);
                frame_whole = 1'b0;
            end else begin
                count       = eff * eff;
                frame_whole = 1'b1;
            end
            send_frame(count);
            sent += count;
        end
    endtask

    // ------------------------------------------------------------------------
    // Result receiver: drops ready at random, and on request holds it low for
    // a long stretch so that the block fills up and pushes back on its input.
    // ------------------------------------------------------------------------
    initial begin
        res_ch.ready = 1'b0;
        hold_served  = 0;
        forever begin
            @(negedge i_clk);
            if (hold_served != hold_asked) begin
                hold_served++;
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
            end
            res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor and watchdog. Every accepted result beat goes to the
    // checker. The watchdog counts cycles in which neither channel moves a
    // beat and no register access is under way, and fails the run at the limit.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned stall_count;
        t_mean_beat  got;
        stall_count = 0;
        while (stall_count < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n && res_ch.valid && res_ch.ready) begin
                got.out_row    = res_ch.out_row;
                got.out_column = res_ch.out_column;
                got.smoothed   = res_ch.smoothed;
                got.run_last   = res_ch.run_last;
                got.frame_done = res_ch.frame_done;
                board.check_result(got);
            end
            if ((pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) || psel)
                stall_count = 0;
            else
                stall_count++;
        end
        $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned k;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel  = '0;
        hold_asked    = 0;
        send_idle_pct = 15;
        recv_idle_pct = 63;

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part. Under the reset side of 8, the whole first row and the
        // first pixel of row 1 release nothing; pixel (1,1) then releases the
        // top-left corner, whose four pixels are all at full scale.
        for (k = 0; k < 10; k++)
            send_pixel((k % 8 < 2) ? PIX_MAX : PIX_MIN);

        // A complete 3x3 image of alternating extremes: every corner, edge and
        // the centre, with the four-result burst on the last pixel.
        wait_results_done();
        write_reg(int'(bmea_pkg::REG_IMAGE_SIDE), 32'd3);
        for (k = 0; k < 9; k++)
            send_pixel((k % 2 != 0) ? PIX_MAX : PIX_MIN);

        // A write to an address with no register must change nothing: the side
        // stays 3, so the next four pixels release no result at all.
        wait_results_done();
        write_reg(SPARE_REG_IDX, 32'd2);
        for (k = 0; k < 4; k++)
            send_pixel(PIX_MAX);

        // Random part, first with a slow receiver, then with a slow sender.
        run_random_frames(10);
        send_idle_pct = 63;
        recv_idle_pct = 15;
        run_random_frames(10);

        // Largest image at full rate. The receiver stalls for a long stretch at
        // its start while pixels keep coming, so the block must stall its input.
        wait_results_done();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_reg(int'(bmea_pkg::REG_IMAGE_SIDE), 32'd16);
        hold_asked++;
        send_frame(SIDE_MAX * SIDE_MAX);

        wait_results_done();
        if (board.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
